FILE: hw/rtl/legacy_irq_route_resolver_macros.svh
// ----------------------------------------------------------------------------
// legacy irq route resolver assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LEGACY_IRQ_ROUTE_RESOLVER_MACROS_SVH
`define LEGACY_IRQ_ROUTE_RESOLVER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LIRR_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("lirr assertion failed: same-cycle implication");
// next-cycle implication
`define LIRR_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("lirr assertion failed: next-cycle implication");
`else
`define LIRR_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons)
`define LIRR_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons)
`endif

`endif

FILE: hw/rtl/lirr_pkg.sv
// ----------------------------------------------------------------------------
// lirr_pkg
// shared types, codes and constants of the legacy irq route resolver
// ----------------------------------------------------------------------------
package lirr_pkg;

  localparam int unsigned MAX_CTRLS_DEF     = 8;
  localparam int unsigned MAX_OVRS_DEF      = 16;
  localparam int unsigned MAX_ROUTES_DEF    = 16;
  localparam int unsigned REDIR_ENTRIES_DEF = 24;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_CTRL = 2'd1,
    OP_ADD_OVR  = 2'd2,
    OP_ROUTE    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_CTRL     = 3'd1,
    ST_IRQ_RANGE   = 3'd2,
    ST_VEC_LOW     = 3'd3,
    ST_ROUTES_FULL = 3'd4,
    ST_UNMAPPED    = 3'd5,
    ST_CTRL_FULL   = 3'd6,
    ST_OVR_FULL    = 3'd7
  } status_t;

  localparam logic [7:0]  IRQ_LIMIT           = 8'd16;
  localparam logic [7:0]  VECTOR_MIN          = 8'd32;
  localparam logic [31:0] REG_INDEX_BASE      = 32'h10;
  localparam int unsigned FLAG_ACTIVE_LOW_BIT = 1;
  localparam int unsigned FLAG_LEVEL_BIT      = 3;

  // controller table entry
  typedef struct packed {
    logic [31:0] base;
    logic        addr_ok;
  } ctrl_ent_t;

  // override table entry, mode bit0 active low, bit1 level
  typedef struct packed {
    logic [7:0]  irq;
    logic [31:0] gsi;
    logic [1:0]  mode;
  } ovr_ent_t;

  // address width of a table of n entries
  function automatic int unsigned idx_w(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

FILE: hw/rtl/lirr_mem.sv
// ----------------------------------------------------------------------------
// lirr_mem
// single-port-write, single-port-read table memory with registered read data
// ----------------------------------------------------------------------------
module lirr_mem #(
  parameter int unsigned DEPTH = lirr_pkg::MAX_CTRLS_DEF,
  parameter int unsigned WIDTH = 33,
  parameter int unsigned AW    = lirr_pkg::idx_w(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  import lirr_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/legacy_irq_route_resolver.sv
// ----------------------------------------------------------------------------
// legacy_irq_route_resolver
// maps legacy irqs through an override table onto interrupt controller windows
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low, and exactly one result
// word comes back for it, shown for a single cycle with out_valid high; the
// receiver cannot stall, so sample it on that cycle. Clear, add-controller,
// add-override and rejected route words never raise busy: the result shows
// on the next cycle, so such words can follow each other
// every cycle. An accepted route word raises busy while it scans the override
// memory and then the controller memory, one entry per cycle through each
// memory's single read port; the result shows in the cycle busy falls, and
// each scan stops early on the first hit in its table. Tables need no
// clearing pass after reset: the fill counts bound every scan, so entries
// are never read before they are written.
`include "legacy_irq_route_resolver_macros.svh"

module legacy_irq_route_resolver #(
  parameter int unsigned MAX_CTRLS       = lirr_pkg::MAX_CTRLS_DEF,
  parameter int unsigned MAX_OVRS        = lirr_pkg::MAX_OVRS_DEF,
  parameter int unsigned MAX_ROUTE_COUNT = lirr_pkg::MAX_ROUTES_DEF,
  parameter int unsigned REDIR_ENTRIES   = lirr_pkg::REDIR_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_ctrl_address,
  input  logic [31:0] in_gsi_base,
  input  logic [7:0]  in_src_irq,
  input  logic [31:0] in_override_gsi,
  input  logic [15:0] in_override_flags,
  input  logic [7:0]  in_legacy_irq,
  input  logic [7:0]  in_vector,
  // result side
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_gsi,
  output logic [2:0]  out_controller_index,
  output logic [4:0]  out_redirection_index,
  output logic [5:0]  out_register_index,
  output logic [15:0] out_low_word,
  output logic        out_writable
);
  import lirr_pkg::*;

  // table address and fill count widths
  localparam int unsigned CAW   = idx_w(MAX_CTRLS);
  localparam int unsigned CCW   = $clog2(MAX_CTRLS + 1);
  localparam int unsigned OAW   = idx_w(MAX_OVRS);
  localparam int unsigned OCW   = $clog2(MAX_OVRS + 1);
  localparam int unsigned RCW   = $clog2(MAX_ROUTE_COUNT + 1);
  localparam int unsigned CTRL_W = $bits(ctrl_ent_t);
  localparam int unsigned OVR_W  = $bits(ovr_ent_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OVR,
    S_CTRL
  } state_t;

  // control state
  state_t         state_r, state_nxt;
  logic [CCW-1:0] ctrl_cnt_r, ctrl_cnt_nxt;
  logic [OCW-1:0] ovr_cnt_r, ovr_cnt_nxt;
  logic [RCW-1:0] route_cnt_r, route_cnt_nxt;
  logic           ctrl_trunc_r, ctrl_trunc_nxt;
  logic           ovr_trunc_r, ovr_trunc_nxt;
  logic           out_valid_r, out_valid_nxt;
  // scan state: read index and "read data is live" flag
  logic [OCW-1:0] oi_r, oi_nxt;
  logic [CCW-1:0] ci_r, ci_nxt;
  logic           rv_r, rv_nxt;

  // route word payload
  logic [7:0]     irq_r, irq_nxt;
  logic [7:0]     vec_r, vec_nxt;
  logic [31:0]    gsi_r, gsi_nxt;
  logic [1:0]     mode_r, mode_nxt;

  // result payload
  status_t        out_status_r, out_status_nxt;
  logic [31:0]    out_gsi_r, out_gsi_nxt;
  logic [2:0]     out_cidx_r, out_cidx_nxt;
  logic [4:0]     out_ridx_r, out_ridx_nxt;
  logic [5:0]     out_reg_r, out_reg_nxt;
  logic [15:0]    out_low_r, out_low_nxt;
  logic           out_wr_r, out_wr_nxt;

  // memory ports
  logic           ctrl_we, ovr_we;
  ctrl_ent_t      ctrl_wdata, ctrl_q;
  ovr_ent_t       ovr_wdata, ovr_q;
  logic [CTRL_W-1:0] ctrl_q_raw;
  logic [OVR_W-1:0]  ovr_q_raw;

  // datapath
  opcode_t        op;
  logic           acc;
  logic           ovr_issue, ctrl_issue;
  logic [32:0]    gsi_ext, base_ext;
  logic           ctrl_hit;
  logic [31:0]    entry_full;
  logic [31:0]    reg_full;
  logic [31:0]    hit_idx;

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;
  assign op   = opcode_t'(in_opcode);

  // ---- table memories ------------------------------------------------------
  // writes only happen on accepted words in idle, reads only while scanning,
  // so the two never touch the same entry in the same cycle

  lirr_mem #(
    .DEPTH (MAX_CTRLS),
    .WIDTH (CTRL_W),
    .AW    (CAW)
  ) u_ctrl_mem (
    .clk     (clk),
    .wr_en   (ctrl_we),
    .wr_addr (ctrl_cnt_r[CAW-1:0]),
    .wr_data (ctrl_wdata),
    .rd_addr (ci_r[CAW-1:0]),
    .rd_data (ctrl_q_raw)
  );

  lirr_mem #(
    .DEPTH (MAX_OVRS),
    .WIDTH (OVR_W),
    .AW    (OAW)
  ) u_ovr_mem (
    .clk     (clk),
    .wr_en   (ovr_we),
    .wr_addr (ovr_cnt_r[OAW-1:0]),
    .wr_data (ovr_wdata),
    .rd_addr (oi_r[OAW-1:0]),
    .rd_data (ovr_q_raw)
  );

  assign ctrl_q = ctrl_ent_t'(ctrl_q_raw);
  assign ovr_q  = ovr_ent_t'(ovr_q_raw);

  assign ctrl_wdata.base    = in_gsi_base;
  assign ctrl_wdata.addr_ok = (in_ctrl_address != 32'd0);
  assign ovr_wdata.irq      = in_src_irq;
  assign ovr_wdata.gsi      = in_override_gsi;
  assign ovr_wdata.mode     = {in_override_flags[FLAG_LEVEL_BIT],
                               in_override_flags[FLAG_ACTIVE_LOW_BIT]};

  // ---- controller window test ---------------------------------------------
  // 33-bit compare so base + window size cannot wrap
  assign ovr_issue  = (oi_r < ovr_cnt_r);
  assign ctrl_issue = (ci_r < ctrl_cnt_r);
  assign gsi_ext    = {1'b0, gsi_r};
  assign base_ext   = {1'b0, ctrl_q.base};
  assign ctrl_hit   = rv_r && (gsi_ext >= base_ext) &&
                      (gsi_ext < (base_ext + 33'(REDIR_ENTRIES)));
  assign entry_full = gsi_r - ctrl_q.base;
  assign reg_full   = REG_INDEX_BASE + (entry_full << 1);
  // live read data belongs to the entry one behind the read index
  assign hit_idx    = 32'(ci_r) - 32'd1;

  // ---- next-state logic ------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    ctrl_cnt_nxt   = ctrl_cnt_r;
    ovr_cnt_nxt    = ovr_cnt_r;
    route_cnt_nxt  = route_cnt_r;
    ctrl_trunc_nxt = ctrl_trunc_r;
    ovr_trunc_nxt  = ovr_trunc_r;
    oi_nxt         = oi_r;
    ci_nxt         = ci_r;
    rv_nxt         = rv_r;
    irq_nxt        = irq_r;
    vec_nxt        = vec_r;
    gsi_nxt        = gsi_r;
    mode_nxt       = mode_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_gsi_nxt    = 32'd0;
    out_cidx_nxt   = 3'd0;
    out_ridx_nxt   = 5'd0;
    out_reg_nxt    = 6'd0;
    out_low_nxt    = 16'd0;
    out_wr_nxt     = 1'b0;
    ctrl_we        = 1'b0;
    ovr_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (op)
            OP_CLEAR: begin
              ctrl_cnt_nxt   = '0;
              ovr_cnt_nxt    = '0;
              route_cnt_nxt  = '0;
              ctrl_trunc_nxt = 1'b0;
              ovr_trunc_nxt  = 1'b0;
              out_valid_nxt  = 1'b1;
            end
            OP_ADD_CTRL: begin
              out_valid_nxt = 1'b1;
              if (ctrl_cnt_r >= CCW'(MAX_CTRLS)) begin
                ctrl_trunc_nxt = 1'b1;
                out_status_nxt = ST_CTRL_FULL;
              end else begin
                ctrl_we      = 1'b1;
                ctrl_cnt_nxt = ctrl_cnt_r + 1'b1;
              end
            end
            OP_ADD_OVR: begin
              out_valid_nxt = 1'b1;
              if (ovr_cnt_r >= OCW'(MAX_OVRS)) begin
                ovr_trunc_nxt  = 1'b1;
                out_status_nxt = ST_OVR_FULL;
              end else begin
                ovr_we      = 1'b1;
                ovr_cnt_nxt = ovr_cnt_r + 1'b1;
              end
            end
            OP_ROUTE: begin
              // checks in priority order, a reject changes no state
              priority if (ctrl_cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NO_CTRL;
              end else if (in_legacy_irq >= IRQ_LIMIT) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_IRQ_RANGE;
              end else if (in_vector < VECTOR_MIN) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_VEC_LOW;
              end else if (route_cnt_r >= RCW'(MAX_ROUTE_COUNT)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_ROUTES_FULL;
              end else begin
                irq_nxt   = in_legacy_irq;
                vec_nxt   = in_vector;
                gsi_nxt   = {24'd0, in_legacy_irq};
                mode_nxt  = 2'b00;
                oi_nxt    = '0;
                rv_nxt    = 1'b0;
                state_nxt = S_OVR;
              end
            end
            default: ;
          endcase
        end
      end

      S_OVR: begin
        // pipelined scan: issue entry n while checking entry n-1
        rv_nxt = ovr_issue;
        oi_nxt = ovr_issue ? (oi_r + 1'b1) : oi_r;
        if (rv_r && (ovr_q.irq == irq_r)) begin
          gsi_nxt   = ovr_q.gsi;
          mode_nxt  = ovr_q.mode;
          ci_nxt    = '0;
          rv_nxt    = 1'b0;
          state_nxt = S_CTRL;
        end else if (!ovr_issue && !rv_r) begin
          // no override, keep the irq as gsi
          ci_nxt    = '0;
          state_nxt = S_CTRL;
        end
      end

      S_CTRL: begin
        rv_nxt = ctrl_issue;
        ci_nxt = ctrl_issue ? (ci_r + 1'b1) : ci_r;
        if (ctrl_hit) begin
          route_cnt_nxt  = route_cnt_r + 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_gsi_nxt    = gsi_r;
          out_cidx_nxt   = hit_idx[2:0];
          out_ridx_nxt   = entry_full[4:0];
          out_reg_nxt    = reg_full[5:0];
          out_low_nxt    = {mode_r[1], 1'b0, mode_r[0], 5'd0, vec_r};
          out_wr_nxt     = ctrl_q.addr_ok;
          rv_nxt         = 1'b0;
          state_nxt      = S_IDLE;
        end else if (!ctrl_issue && !rv_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_UNMAPPED;
          out_gsi_nxt    = gsi_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---- registers -------------------------------------------------------------
  always_ff @(posedge clk) begin
    // payload, no reset needed
    oi_r         <= oi_nxt;
    ci_r         <= ci_nxt;
    irq_r        <= irq_nxt;
    vec_r        <= vec_nxt;
    gsi_r        <= gsi_nxt;
    mode_r       <= mode_nxt;
    out_status_r <= out_status_nxt;
    out_gsi_r    <= out_gsi_nxt;
    out_cidx_r   <= out_cidx_nxt;
    out_ridx_r   <= out_ridx_nxt;
    out_reg_r    <= out_reg_nxt;
    out_low_r    <= out_low_nxt;
    out_wr_r     <= out_wr_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ctrl_cnt_r   <= '0;
      ovr_cnt_r    <= '0;
      route_cnt_r  <= '0;
      ctrl_trunc_r <= 1'b0;
      ovr_trunc_r  <= 1'b0;
      rv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ctrl_cnt_r   <= ctrl_cnt_nxt;
      ovr_cnt_r    <= ovr_cnt_nxt;
      route_cnt_r  <= route_cnt_nxt;
      ctrl_trunc_r <= ctrl_trunc_nxt;
      ovr_trunc_r  <= ovr_trunc_nxt;
      rv_r         <= rv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_gsi               = out_gsi_r;
  assign out_controller_index  = out_cidx_r;
  assign out_redirection_index = out_ridx_r;
  assign out_register_index    = out_reg_r;
  assign out_low_word          = out_low_r;
  assign out_writable          = out_wr_r;

  // ---- assertions ------------------------------------------------------------
  // no table write while a scan reads the memories
  `LIRR_ASSERT_IMPL(a_no_write_in_scan, clk, rst_n, busy, !ctrl_we && !ovr_we)
  // truncation only flagged once the table is full
  `LIRR_ASSERT_IMPL(a_ctrl_trunc_full, clk, rst_n, ctrl_trunc_r, ctrl_cnt_r == CCW'(MAX_CTRLS))
  `LIRR_ASSERT_IMPL(a_ovr_trunc_full, clk, rst_n, ovr_trunc_r, ovr_cnt_r == OCW'(MAX_OVRS))
  // a window hit gives an ok result word on the next cycle
  `LIRR_ASSERT_NEXT(a_hit_gives_ok, clk, rst_n, (state_r == S_CTRL) && ctrl_hit, out_valid_r && (out_status_r == ST_OK))

endmodule
